FILE: hw/rtl/rau_pkg.sv
// Shared types, constants and helpers of the rational arithmetic unit.
`default_nettype none

package rau_pkg;

  // Operand word width; operand fields are taken as this many bits, sign-extended.
  localparam int unsigned WordWidth = 32;
  localparam int unsigned ProdWidth = 66;
  localparam int unsigned QueueDepth = 2;

  localparam logic [1:0] ModeAdd = 2'd0;
  localparam logic [1:0] ModeSub = 2'd1;
  localparam logic [1:0] ModeMul = 2'd2;
  localparam logic [1:0] ModeDiv = 2'd3;

  localparam logic [1:0] StatusOk      = 2'd0;
  localparam logic [1:0] StatusZeroDen = 2'd1;
  localparam logic [1:0] StatusDivZero = 2'd2;
  localparam logic [1:0] StatusOverflow = 2'd3;

  // Largest positive operand value, as a 32-bit magnitude.
  localparam logic [31:0] MaxMag = 32'((64'd1 << (WordWidth - 1)) - 64'd1);
  localparam logic signed [ProdWidth-1:0] MaxVal =
    ProdWidth'((66'sd1 <<< (WordWidth - 1)) - 66'sd1);
  localparam logic signed [ProdWidth-1:0] MinVal = -MaxVal - ProdWidth'(1);

  typedef struct packed {
    logic [1:0]         mode;
    logic signed [31:0] a_num;
    logic signed [31:0] a_den;
    logic signed [31:0] b_num;
    logic signed [31:0] b_den;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] res_num;
    logic [30:0]        res_den;
    logic               less;
    logic               equal;
    logic [1:0]         status;
  } out_item_t;

  // Classified operand beat handed from front to back.
  typedef struct packed {
    logic [1:0]  mode;
    logic        zero_den;
    logic [31:0] a_num_mag;
    logic [31:0] a_den_mag;
    logic        a_neg;
    logic [31:0] b_num_mag;
    logic [31:0] b_den_mag;
    logic        b_neg;
  } q_item_t;

  // Take the low WordWidth bits as a signed value.
  function automatic logic signed [31:0] sext_word(input logic [31:0] v);
    logic signed [31:0] t;
    t = $signed(v << (32 - WordWidth));
    return t >>> (32 - WordWidth);
  endfunction

  function automatic logic [31:0] abs_word(input logic signed [31:0] v);
    return v[31] ? 32'(-v) : 32'(v);
  endfunction

  function automatic logic in_range(input logic signed [ProdWidth-1:0] v);
    return (v >= MinVal) && (v <= MaxVal);
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/rau_front.sv
// Front end: accepts operand beats, flags zero denominators, splits sign and magnitude.
`default_nettype none

module rau_front import rau_pkg::*; (
  input  wire logic     in_valid_i,
  output logic          in_ready_o,
  input  wire in_item_t in_i,
  input  wire logic     q_full_i,
  output logic          q_push_o,
  output q_item_t       q_item_o
);

  logic signed [31:0] an, ad, bn, bd;

  // Sign-extend the operand words
  assign an = sext_word(in_i.a_num);
  assign ad = sext_word(in_i.a_den);
  assign bn = sext_word(in_i.b_num);
  assign bd = sext_word(in_i.b_den);

  assign in_ready_o = !q_full_i;
  assign q_push_o   = in_valid_i && !q_full_i;

  // Classify
  always_comb begin
    q_item_o.mode      = in_i.mode;
    q_item_o.zero_den  = (ad == 32'sd0) || (bd == 32'sd0);
    q_item_o.a_num_mag = abs_word(an);
    q_item_o.a_den_mag = abs_word(ad);
    q_item_o.a_neg     = an[31] ^ ad[31];
    q_item_o.b_num_mag = abs_word(bn);
    q_item_o.b_den_mag = abs_word(bd);
    q_item_o.b_neg     = bn[31] ^ bd[31];
  end

endmodule

`default_nettype wire

FILE: hw/rtl/rau_fifo.sv
// Short queue between front and back ends.
`default_nettype none

module rau_fifo import rau_pkg::*; (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    push_i,
  input  wire q_item_t item_i,
  output logic         full_o,
  input  wire logic    pop_i,
  output logic         empty_o,
  output q_item_t      item_o
);

  localparam int unsigned PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  q_item_t           mem_q [QueueDepth];
  logic [PtrW-1:0]   wptr_q, rptr_q;
  logic [CntW-1:0]   cnt_q;

  assign full_o  = (cnt_q == CntW'(QueueDepth));
  assign empty_o = (cnt_q == '0);
  assign item_o  = mem_q[rptr_q];

  // Storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= item_i;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= (wptr_q == PtrW'(QueueDepth - 1)) ? '0 : wptr_q + PtrW'(1);
      end
      if (pop_i) begin
        rptr_q <= (rptr_q == PtrW'(QueueDepth - 1)) ? '0 : rptr_q + PtrW'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/rau_gcd.sv
// Iterative binary gcd of two 32-bit magnitudes, one step per cycle.
`default_nettype none

module rau_gcd (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [31:0] x_i,
  input  wire logic [31:0] y_i,
  output logic             done_o,
  output logic [31:0]      g_o
);

  logic        busy_q, done_q;
  logic [31:0] a_q, b_q, g_q;
  logic [4:0]  k_q;

  assign done_o = done_q;
  assign g_o    = g_q;

  // Control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
      end else if (busy_q && (a_q == '0 || b_q == '0)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  // Datapath: strip common twos, then subtract-and-halve
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q <= x_i;
      b_q <= y_i;
      k_q <= '0;
    end else if (busy_q) begin
      if (a_q == '0) begin
        g_q <= b_q << k_q;
      end else if (b_q == '0) begin
        g_q <= a_q << k_q;
      end else if (!a_q[0] && !b_q[0]) begin
        a_q <= a_q >> 1;
        b_q <= b_q >> 1;
        k_q <= k_q + 5'd1;
      end else if (!a_q[0]) begin
        a_q <= a_q >> 1;
      end else if (!b_q[0]) begin
        b_q <= b_q >> 1;
      end else if (a_q >= b_q) begin
        a_q <= (a_q - b_q) >> 1;
      end else begin
        b_q <= (b_q - a_q) >> 1;
      end
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/rau_div.sv
// Dual restoring divider: two dividends over one divisor, one quotient bit per cycle.
`default_nettype none

module rau_div (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [31:0] dvs_i,
  input  wire logic [31:0] dvd0_i,
  input  wire logic [31:0] dvd1_i,
  output logic             done_o,
  output logic [31:0]      q0_o,
  output logic [31:0]      q1_o
);

  logic        busy_q, done_q;
  logic [5:0]  cnt_q;
  logic [31:0] dvs_q, q0_q, q1_q;
  logic [32:0] r0_q, r1_q;
  logic [32:0] r0_sh, r1_sh;

  assign done_o = done_q;
  assign q0_o   = q0_q;
  assign q1_o   = q1_q;

  assign r0_sh = {r0_q[31:0], q0_q[31]};
  assign r1_sh = {r1_q[31:0], q1_q[31]};

  // Control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 6'd1;
        if (cnt_q == 6'd31) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Datapath: quotient bits shift in where dividend bits shift out
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvs_q <= dvs_i;
      q0_q  <= dvd0_i;
      q1_q  <= dvd1_i;
      r0_q  <= '0;
      r1_q  <= '0;
    end else if (busy_q) begin
      if (r0_sh >= {1'b0, dvs_q}) begin
        r0_q <= r0_sh - {1'b0, dvs_q};
        q0_q <= {q0_q[30:0], 1'b1};
      end else begin
        r0_q <= r0_sh;
        q0_q <= {q0_q[30:0], 1'b0};
      end
      if (r1_sh >= {1'b0, dvs_q}) begin
        r1_q <= r1_sh - {1'b0, dvs_q};
        q1_q <= {q1_q[30:0], 1'b1};
      end else begin
        r1_q <= r1_sh;
        q1_q <= {q1_q[30:0], 1'b0};
      end
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/rau_back.sv
// Back end: sequencer that reduces operands, compares, applies the operation, reduces result.
`default_nettype none

module rau_back import rau_pkg::*; (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    q_empty_i,
  input  wire q_item_t q_item_i,
  output logic         q_pop_o,
  output logic         out_valid_o,
  input  wire logic    out_ready_i,
  output out_item_t    out_o
);

  localparam logic [3:0] SIdle  = 4'd0;
  localparam logic [3:0] SGcdGo = 4'd1;
  localparam logic [3:0] SGcdW  = 4'd2;
  localparam logic [3:0] SDivGo = 4'd3;
  localparam logic [3:0] SDivW  = 4'd4;
  localparam logic [3:0] SMul0  = 4'd5;
  localparam logic [3:0] SMul1  = 4'd6;
  localparam logic [3:0] SMul2  = 4'd7;
  localparam logic [3:0] SMul3  = 4'd8;
  localparam logic [3:0] SSum   = 4'd9;
  localparam logic [3:0] SChk   = 4'd10;
  localparam logic [3:0] SOut   = 4'd11;

  localparam logic [1:0] PhA   = 2'd0;
  localparam logic [1:0] PhB   = 2'd1;
  localparam logic [1:0] PhRes = 2'd2;

  logic [3:0]  state_q, state_d;
  logic [1:0]  phase_q;
  q_item_t     item_q;
  logic [31:0] red_x_q, red_y_q, g_q;
  logic        red_neg_q;
  logic signed [32:0] ran_q, rbn_q, res_n_q;
  logic [31:0] rad_q, rbd_q, res_d_q;
  logic signed [ProdWidth-1:0] p1_q, p2_q, pd_q, pn_q, n_q;
  logic [1:0]  status_q;
  logic        less_q, equal_q;
  logic        out_valid_q;
  out_item_t   out_q;

  logic        gcd_start, gcd_done, div_start, div_done;
  logic [31:0] gcd_g, div_q0, div_q1;
  logic        q_neg;
  logic signed [32:0] q_num;
  logic signed [32:0] ma, mb;
  logic signed [ProdWidth-1:0] prod;
  logic        op_ovf, chk_ovf, res_ovf;
  logic [1:0]  chk_status;
  logic        out_free;

  rau_gcd u_gcd (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (gcd_start),
    .x_i     (red_x_q),
    .y_i     (red_y_q),
    .done_o  (gcd_done),
    .g_o     (gcd_g)
  );

  rau_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .dvs_i   (g_q),
    .dvd0_i  (red_x_q),
    .dvd1_i  (red_y_q),
    .done_o  (div_done),
    .q0_o    (div_q0),
    .q1_o    (div_q1)
  );

  assign gcd_start = (state_q == SGcdGo);
  assign div_start = (state_q == SDivGo);
  assign out_free  = !out_valid_q || out_ready_i;
  assign q_pop_o   = (state_q == SIdle) && !q_empty_i;

  // Signed quotient: zero stays positive
  assign q_neg = red_neg_q && (div_q0 != '0);
  assign q_num = q_neg ? -$signed({1'b0, div_q0}) : $signed({1'b0, div_q0});

  // Shared multiplier operand select
  always_comb begin
    ma = ran_q;
    mb = $signed({1'b0, rbd_q});
    case (state_q)
      SMul0: begin
        ma = ran_q;
        mb = $signed({1'b0, rbd_q});
      end
      SMul1: begin
        ma = rbn_q;
        mb = $signed({1'b0, rad_q});
      end
      SMul2: begin
        ma = $signed({1'b0, rad_q});
        mb = (item_q.mode == ModeDiv) ? rbn_q : $signed({1'b0, rbd_q});
      end
      SMul3: begin
        ma = ran_q;
        mb = rbn_q;
      end
      default: begin
        ma = ran_q;
        mb = $signed({1'b0, rbd_q});
      end
    endcase
  end
  assign prod = ProdWidth'(ma) * ProdWidth'(mb);

  // Operand and operation range checks
  always_comb begin
    op_ovf  = !in_range(ProdWidth'(ran_q)) || (rad_q > MaxMag) ||
              !in_range(ProdWidth'(rbn_q)) || (rbd_q > MaxMag);
    chk_ovf = !in_range(n_q) || !in_range(pd_q);
    if (item_q.mode == ModeAdd || item_q.mode == ModeSub) begin
      chk_ovf = chk_ovf || !in_range(p1_q) || !in_range(p2_q);
    end
    if (item_q.mode == ModeDiv && rbn_q == '0) begin
      chk_status = StatusDivZero;
    end else if (op_ovf || chk_ovf) begin
      chk_status = StatusOverflow;
    end else begin
      chk_status = StatusOk;
    end
  end

  assign res_ovf = ((div_q0 > MaxMag) && !q_neg) || (div_q1 > MaxMag);

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      SIdle:  if (!q_empty_i) state_d = q_item_i.zero_den ? SOut : SGcdGo;
      SGcdGo: state_d = SGcdW;
      SGcdW:  if (gcd_done) state_d = SDivGo;
      SDivGo: state_d = SDivW;
      SDivW: begin
        if (div_done) begin
          case (phase_q)
            PhA:     state_d = SGcdGo;
            PhB:     state_d = SMul0;
            default: state_d = SOut;
          endcase
        end
      end
      SMul0:  state_d = SMul1;
      SMul1:  state_d = SMul2;
      SMul2:  state_d = SMul3;
      SMul3:  state_d = SSum;
      SSum:   state_d = SChk;
      SChk:   state_d = (chk_status == StatusOk) ? SGcdGo : SOut;
      SOut:   if (out_free) state_d = SIdle;
      default: state_d = SIdle;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SIdle;
      phase_q     <= PhA;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == SIdle && !q_empty_i) begin
        phase_q <= PhA;
      end else if (state_q == SDivW && div_done && phase_q == PhA) begin
        phase_q <= PhB;
      end else if (state_q == SChk) begin
        phase_q <= PhRes;
      end
      if (state_q == SOut && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      SIdle: begin
        item_q    <= q_item_i;
        red_x_q   <= q_item_i.a_num_mag;
        red_y_q   <= q_item_i.a_den_mag;
        red_neg_q <= q_item_i.a_neg;
        status_q  <= q_item_i.zero_den ? StatusZeroDen : StatusOk;
        less_q    <= 1'b0;
        equal_q   <= 1'b0;
      end
      SGcdW: if (gcd_done) g_q <= gcd_g;
      SDivW: begin
        if (div_done) begin
          case (phase_q)
            PhA: begin
              ran_q     <= q_num;
              rad_q     <= div_q1;
              red_x_q   <= item_q.b_num_mag;
              red_y_q   <= item_q.b_den_mag;
              red_neg_q <= item_q.b_neg;
            end
            PhB: begin
              rbn_q <= q_num;
              rbd_q <= div_q1;
            end
            default: begin
              res_n_q <= q_num;
              res_d_q <= div_q1;
              if (res_ovf) status_q <= StatusOverflow;
            end
          endcase
        end
      end
      SMul0: p1_q <= prod;
      SMul1: p2_q <= prod;
      SMul2: pd_q <= prod;
      SMul3: pn_q <= prod;
      SSum: begin
        less_q  <= (p1_q < p2_q);
        equal_q <= (ran_q == rbn_q) && (rad_q == rbd_q);
        case (item_q.mode)
          ModeAdd: n_q <= p1_q + p2_q;
          ModeSub: n_q <= p1_q - p2_q;
          ModeMul: n_q <= pn_q;
          default: n_q <= p1_q;
        endcase
      end
      SChk: begin
        status_q  <= chk_status;
        red_x_q   <= n_q[ProdWidth-1] ? 32'(-n_q) : n_q[31:0];
        red_y_q   <= pd_q[ProdWidth-1] ? 32'(-pd_q) : pd_q[31:0];
        red_neg_q <= n_q[ProdWidth-1] ^ pd_q[ProdWidth-1];
      end
      default: begin
      end
    endcase
  end

  // Result register
  always_ff @(posedge clk_i) begin
    if (state_q == SOut && out_free) begin
      out_q.less   <= less_q;
      out_q.equal  <= equal_q;
      out_q.status <= status_q;
      if (status_q == StatusOk) begin
        out_q.res_num <= res_n_q[31:0];
        out_q.res_den <= res_d_q[30:0];
      end else begin
        out_q.res_num <= '0;
        out_q.res_den <= 31'd1;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule

`default_nettype wire

FILE: hw/rtl/rational_arithmetic_unit_top.sv
// Rational arithmetic unit: two fractions in, reduced result and compare flags out.
// Zero-denominator items skip the reductions and go straight to the output state. The back
// end takes one item at a time; its three reductions run through the shared gcd unit and
// the dual divider. A 2-beat queue lets the front accept while the back works. Reset
// clears all control state.
`default_nettype none

module rational_arithmetic_unit_top import rau_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_ready_o,
  input  wire in_item_t in_i,
  output logic          out_valid_o,
  input  wire logic     out_ready_i,
  output out_item_t     out_o
);

  logic    q_full, q_push, q_empty, q_pop;
  q_item_t q_in, q_out;

  rau_front u_front (
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_i       (in_i),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_item_o   (q_in)
  );

  rau_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .item_i  (q_in),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .item_o  (q_out)
  );

  rau_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_empty_i   (q_empty),
    .q_item_i    (q_out),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_o       (out_o)
  );

  // Error beats carry the zero result 0/1
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_o.status != StatusOk |-> out_o.res_num == '0 && out_o.res_den == 31'd1)
    else $error("error beat without zero result");

  // Denominator is never zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_o.res_den != '0)
    else $error("zero result denominator");

  // Zero-denominator beats carry no compare flags
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_o.status == StatusZeroDen |-> !out_o.less && !out_o.equal)
    else $error("flags set on zero denominator");

  // Equal and less are exclusive
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(out_o.less && out_o.equal))
    else $error("less and equal both set");

endmodule

`default_nettype wire

FILE: tb/sv/tb_top.sv
// Testbench for the rational arithmetic unit: directed and random fractions, scoreboard check.
`default_nettype none

module tb_top import rau_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid_i = 1'b0;
  logic      in_ready_o;
  in_item_t  in_i = '0;
  logic      out_valid_o;
  logic      out_ready_i = 1'b0;
  out_item_t out_o;

  rational_arithmetic_unit_top dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_ready_o(in_ready_o), .in_i(in_i),
    .out_valid_o(out_valid_o), .out_ready_i(out_ready_i), .out_o(out_o)
  );

  always #5 clk_i = ~clk_i;

  out_item_t   pending_results[$];
  int unsigned errors = 0;
  int unsigned cycles = 0;
  int unsigned results_seen = 0;
  int unsigned hold_cycles = 0;   // receiver forced stall, counted down
  bit          rx_busy_mode = 1'b1;
  int unsigned n_ok = 0, n_zden = 0, n_dz = 0, n_ovf = 0;

  localparam longint LimitCycles = 3_000_000;

  // Timeout guard
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LimitCycles) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Helpers on 64-bit signed values
  function automatic longint sx(input logic [31:0] v);
    longint t;
    t = longint'($signed(v << (32 - WordWidth)));
    return t >>> (32 - WordWidth);
  endfunction

  function automatic bit fits(input longint v);
    longint hi;
    hi = (longint'(1) << (WordWidth - 1)) - 1;
    return v >= -hi - 1 && v <= hi;
  endfunction

  function automatic longint euclid(input longint x, input longint y);
    longint t;
    while (y != 0) begin
      t = x % y;
      x = y;
      y = t;
    end
    return x;
  endfunction

  // Reduce n/d to lowest terms with positive denominator
  task automatic lowest_terms(input longint n, input longint d,
                              output longint rn, output longint rd);
    longint un, ud, g;
    un = n < 0 ? -n : n;
    ud = d < 0 ? -d : d;
    g = euclid(un, ud);
    if (g == 0) g = 1;
    un = un / g;
    ud = ud / g;
    rn = (((n < 0) != (d < 0)) && un != 0) ? -un : un;
    rd = ud;
  endtask

  // Predict the result beat of one operand beat
  task automatic predict_fraction_op(input in_item_t it, output out_item_t r);
    longint an, ad, bn, bd, ran, rad, rbn, rbd, n, d, p1, p2, rn, rd, hi;
    bit ovf;
    an = sx(it.a_num); ad = sx(it.a_den);
    bn = sx(it.b_num); bd = sx(it.b_den);
    hi = (longint'(1) << (WordWidth - 1)) - 1;
    r = '0;
    r.res_den = 31'd1;
    rn = 0; rd = 1;
    if (ad == 0 || bd == 0) begin
      r.status = StatusZeroDen;
    end else begin
      lowest_terms(an, ad, ran, rad);
      lowest_terms(bn, bd, rbn, rbd);
      r.less = (ran * rbd < rbn * rad);
      r.equal = (ran == rbn && rad == rbd);
      if (it.mode == ModeDiv && rbn == 0) begin
        r.status = StatusDivZero;
      end else if (!fits(ran) || rad > hi || !fits(rbn) || rbd > hi) begin
        r.status = StatusOverflow;
      end else begin
        ovf = 1'b0;
        n = 0; d = 1;
        case (it.mode)
          ModeAdd, ModeSub: begin
            p1 = ran * rbd;
            p2 = rbn * rad;
            n = (it.mode == ModeAdd) ? p1 + p2 : p1 - p2;
            d = rad * rbd;
            ovf = !fits(p1) || !fits(p2) || !fits(n);
          end
          ModeMul: begin
            n = ran * rbn;
            d = rad * rbd;
          end
          default: begin
            n = ran * rbd;
            d = rad * rbn;
          end
        endcase
        if (ovf || !fits(n) || !fits(d)) begin
          r.status = StatusOverflow;
        end else begin
          lowest_terms(n, d, rn, rd);
          if (!fits(rn) || rd > hi) begin
            r.status = StatusOverflow;
          end else begin
            r.status = StatusOk;
            r.res_num = 32'(rn);
            r.res_den = 31'(rd);
          end
        end
      end
    end
    case (r.status)
      StatusOk:      n_ok++;
      StatusZeroDen: n_zden++;
      StatusDivZero: n_dz++;
      default:       n_ovf++;
    endcase
  endtask

  function automatic int unsigned gap_len();
    int unsigned p;
    p = $urandom_range(0, 99);
    if (p < 45) return 0;
    if (p < 92) return $urandom_range(1, 4);
    return $urandom_range(20, 300);
  endfunction

  // Send one beat, queue its expected result on acceptance
  task automatic send_item(input in_item_t it, input bit idle_ok = 1'b1);
    out_item_t r;
    int unsigned g;
    g = idle_ok ? gap_len() : 0;
    repeat (g) @(negedge clk_i);
    in_i = it;
    in_valid_i = 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    predict_fraction_op(it, r);
    pending_results.push_back(r);
    @(negedge clk_i);
    in_valid_i = 1'b0;
  endtask

  // Receiver ready: a forced hold-off, steady ready outside busy mode, or random idling
  always @(negedge clk_i) begin
    if (hold_cycles != 0) begin
      out_ready_i <= 1'b0;
      hold_cycles = hold_cycles - 1;
    end else if (!rx_busy_mode) begin
      out_ready_i <= 1'b1;
    end else begin
      out_ready_i <= ($urandom_range(0, 99) < 70) ? 1'b1
                   : ($urandom_range(0, 9) == 0 ? 1'b0 : 1'b1) & ($urandom_range(0, 1) == 1);
    end
  end

  // Result checker
  always @(posedge clk_i) begin
    out_item_t e;
    if (rst_ni && out_valid_o && out_ready_i) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        $error("result beat with no pending expectation");
        errors++;
      end else begin
        e = pending_results.pop_front();
        if (out_o.res_num !== e.res_num) begin
          $error("res_num exp %0d got %0d", e.res_num, out_o.res_num); errors++;
        end
        if (out_o.res_den !== e.res_den) begin
          $error("res_den exp %0d got %0d", e.res_den, out_o.res_den); errors++;
        end
        if (out_o.less !== e.less) begin
          $error("less exp %0b got %0b", e.less, out_o.less); errors++;
        end
        if (out_o.equal !== e.equal) begin
          $error("equal exp %0b got %0b", e.equal, out_o.equal); errors++;
        end
        if (out_o.status !== e.status) begin
          $error("status exp %0d got %0d", e.status, out_o.status); errors++;
        end
      end
    end
  end

  function automatic in_item_t mk(input logic [1:0] m, input int an, input int ad,
                                  input int bn, input int bd);
    in_item_t it;
    it.mode = m; it.a_num = an; it.a_den = ad; it.b_num = bn; it.b_den = bd;
    return it;
  endfunction

  localparam int IMin = 32'sh8000_0000;
  localparam int IMax = 32'sh7fff_ffff;

  task automatic test_directed();
    send_item(mk(ModeAdd, 1, 2, 1, 3));
    send_item(mk(ModeSub, 1, 2, 1, 2));          // zero reads 0/1
    send_item(mk(ModeMul, -3, 4, 8, -9));
    send_item(mk(ModeDiv, 5, -7, -10, 14));
    send_item(mk(ModeAdd, 1, 0, 1, 1));          // zero denominator, a
    send_item(mk(ModeDiv, 1, 1, 0, 0));          // zero den beats divide by zero
    send_item(mk(ModeDiv, 3, 4, 0, -5));         // divide by zero
    send_item(mk(ModeMul, IMin, -1, 1, 1));      // operand overflow
    send_item(mk(ModeAdd, IMin, 1, 1, IMin));    // operand den out of range after sign fix
    send_item(mk(ModeMul, IMax, 1, IMax, 1));    // product overflow
    send_item(mk(ModeAdd, IMax, 1, 1, 1));       // sum overflow
    send_item(mk(ModeSub, IMin, 1, 1, 1));       // difference overflow
    send_item(mk(ModeAdd, IMax, 2, IMax, 3));    // cross product overflow
    send_item(mk(ModeDiv, 1, IMax, 1, IMax - 1));
    send_item(mk(ModeMul, IMin, 2, 1, 1));
    send_item(mk(ModeSub, 0, IMin, 0, IMax));
    send_item(mk(ModeAdd, -1, -1, IMax, IMax));
    send_item(mk(ModeDiv, IMin, IMin, -1, 1));
    send_item(mk(ModeMul, 12, 18, -18, 12));
    send_item(mk(ModeAdd, 6, -4, -3, 2));        // equal operands
  endtask

  function automatic int rnd_word();
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return $signed($urandom_range(0, 40)) - 20;
      2: return $urandom_range(0, 1) ? IMax - $urandom_range(0, 3) : IMin + $urandom_range(0, 3);
      3: return $signed($urandom_range(0, 2000)) - 1000;
      default: return $signed($urandom_range(0, 131072)) - 65536;
    endcase
  endfunction

  function automatic in_item_t rnd_item();
    in_item_t it;
    it.mode = 2'($urandom_range(0, 3));
    it.a_num = rnd_word();
    it.b_num = rnd_word();
    it.a_den = rnd_word();
    it.b_den = rnd_word();
    if ($urandom_range(0, 29) == 0) it.a_den = 0;
    if ($urandom_range(0, 29) == 0) it.b_den = 0;
    if ($urandom_range(0, 19) == 0) it.b_num = 0;
    return it;
  endfunction

  task automatic test_random(input int unsigned count);
    repeat (count) send_item(rnd_item());
  endtask

  // Long receiver hold-off while the sender keeps offering beats back to back
  task automatic test_backpressure();
    hold_cycles = 3000;
    repeat (8) send_item(rnd_item(), 1'b0);
    wait (pending_results.size() == 0);
  endtask

  // Sender pauses until every result is back, then resumes
  task automatic test_drain_pause();
    repeat (20) send_item(rnd_item());
    wait (pending_results.size() == 0);
    rx_busy_mode = 1'b0;
    repeat (30) send_item(rnd_item(), 1'b0);
    wait (pending_results.size() == 0);
    rx_busy_mode = 1'b1;
  endtask

  initial begin
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_directed();
    test_backpressure();
    test_drain_pause();
    test_random(1420);
    wait (pending_results.size() == 0);
    repeat (500) @(posedge clk_i);
    $display("Covered %0d results: %0d ok, %0d zero-denominator, %0d divide-by-zero,",
             results_seen, n_ok, n_zden, n_dz);
    $display("%0d overflow, with long output stalls and drained pauses.", n_ovf);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire
